@@ hdl/slx_pkg.sv @@
package slx_pkg;

  typedef enum logic [3:0] {
    KIND_SEMI    = 4'd0,
    KIND_LPAREN  = 4'd1,
    KIND_RPAREN  = 4'd2,
    KIND_LBRACE  = 4'd3,
    KIND_RBRACE  = 4'd4,
    KIND_LBRACK  = 4'd5,
    KIND_RBRACK  = 4'd6,
    KIND_PLUS2   = 4'd7,
    KIND_PLUS3   = 4'd8,
    KIND_SHR     = 4'd9,
    KIND_STRING  = 4'd10,
    KIND_IDENT   = 4'd11,
    KIND_EOF     = 4'd12,
    KIND_BAD     = 4'd13,
    KIND_UNTERM  = 4'd14
  } kind_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Number of result entries held between the lexer and the output port.
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_US) || (c == CH_DOT) ||
           (c == CH_HASH) || (c == CH_PCT);
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      default:   k = KIND_BAD;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/source_char_lexer_unit.sv @@
// Results are written into the result queue when their item is accepted and leave from its head.
// One item is taken per cycle while s_axis_tready is high; an item may push two results at once.
// A four-entry result queue decouples the sides; s_axis_tready drops while it holds three or more.
// Reset is synchronous: the lexer returns to idle at line 1, column 1, offset 0,
// and the result queue is emptied.
module source_char_lexer_unit #(
  parameter int  POS_WIDTH = 16,
  localparam int FIELD_W   = 4 + 3 * POS_WIDTH + 32 + 8,
  localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // ch
  input  logic               s_axis_tuser,  // is_end
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // token_kind, start_line, start_col, start_offset, token_len, bad_char, zero fill
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam int RES_W   = TDATA_W + 1;

  logic             room;
  logic             accept;
  slx_pkg::push_t   push;
  logic [RES_W-1:0] res0, res1;
  logic [RES_W-1:0] q_data;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid & room;

  slx_core #(.POS_WIDTH(POS_WIDTH)) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (s_axis_tdata),
    .is_end (s_axis_tuser),
    .push   (push),
    .res0   (res0),
    .res1   (res1)
  );

  slx_outq #(.W(RES_W)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din0      (res0),
    .din1      (res1),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (q_data)
  );

  assign m_axis_tdata = q_data[TDATA_W-1:0];
  assign m_axis_tlast = q_data[TDATA_W];

endmodule

@@ hdl/slx_core.sv @@
module slx_core #(
  parameter int  POS_WIDTH = 16,
  localparam int FIELD_W   = 4 + 3 * POS_WIDTH + 32 + 8,
  localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8,
  localparam int RES_W     = TDATA_W + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          ch,
  input  logic                is_end,
  output slx_pkg::push_t      push,
  output logic [RES_W-1:0]    res0,
  output logic [RES_W-1:0]    res1
);

  typedef enum logic [2:0] {
    M_IDLE, M_PLUS1, M_PLUS2, M_GT, M_STR, M_IDENT, M_ERR
  } mode_t;

  typedef struct packed {
    logic [7:0]           bad;
    logic [POS_WIDTH-1:0] len;
    logic [31:0]          off;
    logic [POS_WIDTH-1:0] col;
    logic [POS_WIDTH-1:0] line;
    logic [3:0]           kind;
  } tok_t;

  mode_t                mode, mode_next;
  logic [POS_WIDTH-1:0] cur_line, cur_line_next;
  logic [POS_WIDTH-1:0] cur_col, cur_col_next;
  logic [31:0]          cur_offset, cur_offset_next;
  logic [POS_WIDTH-1:0] tok_line, tok_line_next;
  logic [POS_WIDTH-1:0] tok_col, tok_col_next;
  logic [31:0]          tok_offset, tok_offset_next;
  logic [POS_WIDTH-1:0] tok_len, tok_len_next;

  mode_t                il_mode;
  logic                 il_mark;
  logic                 il_v;
  tok_t                 il_tok;
  tok_t                 held_tok;
  tok_t                 tok_a, tok_b;
  logic                 a_v, b_v;
  logic [POS_WIDTH-1:0] len_inc;

  function automatic logic [POS_WIDTH-1:0] sat_pos(input logic [POS_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign held_tok = '{bad: 8'd0, len: tok_len, off: tok_offset, col: tok_col,
                      line: tok_line, kind: slx_pkg::KIND_BAD};
  assign len_inc  = sat_pos(tok_len);

  always_comb begin
    il_mode = M_IDLE;
    il_mark = 1'b1;
    il_v    = 1'b0;
    il_tok  = '{bad: 8'd0, len: POS_WIDTH'(1), off: cur_offset, col: cur_col,
                line: cur_line, kind: slx_pkg::punct_kind(ch)};
    if (slx_pkg::is_space(ch)) begin
      il_mark = 1'b0;
    end else if (ch == slx_pkg::CH_PLUS) begin
      il_mode = M_PLUS1;
    end else if (ch == slx_pkg::CH_GT) begin
      il_mode = M_GT;
    end else if (slx_pkg::punct_kind(ch) != slx_pkg::KIND_BAD) begin
      il_v = 1'b1;
    end else if (ch == slx_pkg::CH_QUOTE) begin
      il_mode = M_STR;
    end else if (slx_pkg::is_ident(ch)) begin
      il_mode = M_IDENT;
    end else begin
      il_v    = 1'b1;
      il_tok.bad = ch;
      il_mode = M_ERR;
    end
  end

  always_comb begin
    mode_next       = mode;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    cur_offset_next = cur_offset;
    tok_line_next   = tok_line;
    tok_col_next    = tok_col;
    tok_offset_next = tok_offset;
    tok_len_next    = tok_len;
    a_v   = 1'b0;
    b_v   = 1'b0;
    tok_a = held_tok;
    tok_b = il_tok;
    if (accept) begin
      if (is_end) begin
        unique case (mode)
          M_PLUS1: begin
            a_v = 1'b1;
            tok_a.bad = slx_pkg::CH_PLUS;
          end
          M_PLUS2: begin
            a_v = 1'b1;
            tok_a.kind = slx_pkg::KIND_PLUS2;
          end
          M_GT: begin
            a_v = 1'b1;
            tok_a.bad = slx_pkg::CH_GT;
          end
          M_STR: begin
            a_v = 1'b1;
            tok_a.kind = slx_pkg::KIND_UNTERM;
          end
          M_IDENT: begin
            a_v = 1'b1;
            tok_a.kind = slx_pkg::KIND_IDENT;
          end
          default: a_v = 1'b0;
        endcase
        b_v   = 1'b1;
        tok_b = '{bad: 8'd0, len: '0, off: cur_offset, col: cur_col,
                  line: cur_line, kind: slx_pkg::KIND_EOF};
        mode_next       = M_IDLE;
        cur_line_next   = POS_WIDTH'(1);
        cur_col_next    = POS_WIDTH'(1);
        cur_offset_next = '0;
        tok_line_next   = POS_WIDTH'(1);
        tok_col_next    = POS_WIDTH'(1);
        tok_offset_next = '0;
        tok_len_next    = '0;
      end else begin
        unique case (mode)
          M_ERR: a_v = 1'b0;
          M_PLUS1: begin
            if (ch == slx_pkg::CH_PLUS) begin
              tok_len_next = POS_WIDTH'(2);
              mode_next    = M_PLUS2;
            end else begin
              a_v       = 1'b1;
              tok_a.bad = slx_pkg::CH_PLUS;
              mode_next = M_ERR;
            end
          end
          M_GT: begin
            a_v = 1'b1;
            if (ch == slx_pkg::CH_GT) begin
              tok_a.kind = slx_pkg::KIND_SHR;
              tok_a.len  = POS_WIDTH'(2);
              mode_next  = M_IDLE;
            end else begin
              tok_a.bad = slx_pkg::CH_GT;
              mode_next = M_ERR;
            end
          end
          M_STR: begin
            tok_len_next = len_inc;
            if (ch == slx_pkg::CH_QUOTE) begin
              a_v        = 1'b1;
              tok_a.kind = slx_pkg::KIND_STRING;
              tok_a.len  = len_inc;
              mode_next  = M_IDLE;
            end
          end
          M_PLUS2, M_IDENT: begin
            if ((mode == M_PLUS2) && (ch == slx_pkg::CH_PLUS)) begin
              a_v        = 1'b1;
              tok_a.kind = slx_pkg::KIND_PLUS3;
              tok_a.len  = POS_WIDTH'(3);
              mode_next  = M_IDLE;
            end else if ((mode == M_IDENT) && slx_pkg::is_ident(ch)) begin
              tok_len_next = len_inc;
            end else begin
              a_v        = 1'b1;
              tok_a.kind = (mode == M_PLUS2) ? slx_pkg::KIND_PLUS2 : slx_pkg::KIND_IDENT;
              b_v        = il_v;
              mode_next  = il_mode;
              if (il_mark) begin
                tok_line_next   = cur_line;
                tok_col_next    = cur_col;
                tok_offset_next = cur_offset;
                tok_len_next    = POS_WIDTH'(1);
              end
            end
          end
          default: begin
            b_v       = il_v;
            mode_next = il_mode;
            if (il_mark) begin
              tok_line_next   = cur_line;
              tok_col_next    = cur_col;
              tok_offset_next = cur_offset;
              tok_len_next    = POS_WIDTH'(1);
            end
          end
        endcase
        if (ch == slx_pkg::CH_LF) begin
          cur_line_next = sat_pos(cur_line);
          cur_col_next  = POS_WIDTH'(1);
        end else begin
          cur_col_next = sat_pos(cur_col);
        end
        cur_offset_next = (&cur_offset) ? cur_offset : cur_offset + 32'd1;
      end
    end
  end

  assign push.first  = a_v | b_v;
  assign push.second = a_v & b_v;
  assign res0 = a_v ? {~b_v, TDATA_W'(tok_a)} : {1'b1, TDATA_W'(tok_b)};
  assign res1 = {1'b1, TDATA_W'(tok_b)};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      cur_line   <= POS_WIDTH'(1);
      cur_col    <= POS_WIDTH'(1);
      cur_offset <= '0;
      tok_line   <= POS_WIDTH'(1);
      tok_col    <= POS_WIDTH'(1);
      tok_offset <= '0;
      tok_len    <= '0;
    end else begin
      mode       <= mode_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      cur_offset <= cur_offset_next;
      tok_line   <= tok_line_next;
      tok_col    <= tok_col_next;
      tok_offset <= tok_offset_next;
      tok_len    <= tok_len_next;
    end
  end

endmodule

@@ hdl/slx_outq.sv @@
module slx_outq #(
  parameter int W = 97
) (
  input  logic           clk,
  input  logic           rst,
  input  slx_pkg::push_t push,
  input  logic [W-1:0]   din0,
  input  logic [W-1:0]   din1,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [W-1:0]   out_data
);

  localparam int PW = $clog2(slx_pkg::Q_DEPTH);
  localparam int CW = $clog2(slx_pkg::Q_DEPTH + 1);

  logic [W-1:0]  mem [slx_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;
  logic [CW-1:0] n_push;

  assign pop       = out_valid & out_ready;
  assign n_push    = CW'(push.first) + CW'(push.second);
  assign room      = count <= CW'(slx_pkg::Q_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + n_push - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= din0;
    end
    if (push.second) begin
      mem[PW'(wr_ptr + 1'b1)] <= din1;
    end
  end

endmodule

@@ hdl/slx_checker.sv @@
module slx_checker #(
  parameter int  POS_WIDTH = 16,
  localparam int FIELD_W   = 4 + 3 * POS_WIDTH + 32 + 8,
  localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast
);

  localparam int BAD_LSB = 4 + 3 * POS_WIDTH + 32;

  logic [3:0] kind;
  logic [7:0] bad;

  assign kind = m_axis_tdata[3:0];
  assign bad  = m_axis_tdata[BAD_LSB +: 8];

  // A stalled result transaction keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast))
    else $error("stalled result changed");

  // The input side only stalls while results are queued.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result queue");

  // End of file always closes the results of its transaction.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (kind == slx_pkg::KIND_EOF) |-> m_axis_tlast)
    else $error("eof without tlast");

  // Only an error token (KIND_BAD) carries the offending byte.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (kind != slx_pkg::KIND_BAD) |-> bad == 8'd0)
    else $error("bad_char set on a non-error token");

  a_reset_ready: assert property (@(posedge clk)
    !rst && $past(rst) |-> s_axis_tready && !m_axis_tvalid)
    else $error("not empty and ready after reset");

endmodule

bind source_char_lexer_unit slx_checker #(.POS_WIDTH(POS_WIDTH)) u_slx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ verif/testbench.sv @@
module testbench;
  import slx_pkg::*;

  localparam int TDATA_W = 96;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLUS,
    ST_PLUS_PLUS,
    ST_GT,
    ST_QUOTE,
    ST_WORD,
    ST_DRAIN
  } lex_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [31:0] offset;
    logic [15:0] len;
    logic [7:0]  bad;
    logic        last;
  } token_t;

  class token_scoreboard;
    lex_state_t  state;
    logic [15:0] line_now;
    logic [15:0] col_now;
    logic [31:0] offset_now;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [31:0] tok_offset;
    logic [15:0] tok_len;
    token_t      awaited[$];
    token_t      step_out[$];
    int          mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      state = ST_IDLE;
      line_now = 16'd1;
      col_now = 16'd1;
      offset_now = 32'd0;
      tok_line = 16'd1;
      tok_col = 16'd1;
      tok_offset = 32'd0;
      tok_len = 16'd0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [15:0] bump16(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit word_byte(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == CH_US || c == CH_DOT ||
             c == CH_HASH || c == CH_PCT;
    endfunction

    function bit blank_byte(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit punct_of(logic [7:0] c, output kind_t k);
      k = KIND_BAD;
      case (c)
        CH_SEMI:   k = KIND_SEMI;
        CH_LPAREN: k = KIND_LPAREN;
        CH_RPAREN: k = KIND_RPAREN;
        CH_LBRACE: k = KIND_LBRACE;
        CH_RBRACE: k = KIND_RBRACE;
        CH_LBRACK: k = KIND_LBRACK;
        CH_RBRACK: k = KIND_RBRACK;
        default:   return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void emit(kind_t k, logic [15:0] ln, logic [15:0] cl, logic [31:0] off,
                       logic [15:0] len, logic [7:0] bad);
      token_t t;
      t.kind = k;
      t.line = ln;
      t.col = cl;
      t.offset = off;
      t.len = len;
      t.bad = bad;
      t.last = 1'b0;
      step_out.insert(step_out.size(), t);
    endfunction

    function void emit_open(kind_t k, logic [7:0] bad);
      emit(k, tok_line, tok_col, tok_offset, tok_len, bad);
    endfunction

    function void begin_token(logic [7:0] c);
      kind_t k;
      state = ST_IDLE;
      if (blank_byte(c)) return;
      tok_line = line_now;
      tok_col = col_now;
      tok_offset = offset_now;
      tok_len = 16'd1;
      if (c == CH_PLUS) begin
        state = ST_PLUS;
      end else if (c == CH_GT) begin
        state = ST_GT;
      end else if (punct_of(c, k)) begin
        emit_open(k, 8'd0);
      end else if (c == CH_QUOTE) begin
        state = ST_QUOTE;
      end else if (word_byte(c)) begin
        state = ST_WORD;
      end else begin
        emit_open(KIND_BAD, c);
        state = ST_DRAIN;
      end
    endfunction

    function void note_char(logic [7:0] c, logic is_end);
      step_out.delete();
      if (is_end) begin
        case (state)
          ST_PLUS:      emit_open(KIND_BAD, CH_PLUS);
          ST_PLUS_PLUS: emit_open(KIND_PLUS2, 8'd0);
          ST_GT:        emit_open(KIND_BAD, CH_GT);
          ST_QUOTE:     emit_open(KIND_UNTERM, 8'd0);
          ST_WORD:      emit_open(KIND_IDENT, 8'd0);
          default: ;
        endcase
        emit(KIND_EOF, line_now, col_now, offset_now, 16'd0, 8'd0);
        restart();
      end else begin
        case (state)
          ST_DRAIN: ;
          ST_PLUS: begin
            if (c == CH_PLUS) begin
              tok_len = 16'd2;
              state = ST_PLUS_PLUS;
            end else begin
              emit_open(KIND_BAD, CH_PLUS);
              state = ST_DRAIN;
            end
          end
          ST_PLUS_PLUS: begin
            if (c == CH_PLUS) begin
              tok_len = 16'd3;
              emit_open(KIND_PLUS3, 8'd0);
              state = ST_IDLE;
            end else begin
              emit_open(KIND_PLUS2, 8'd0);
              begin_token(c);
            end
          end
          ST_GT: begin
            if (c == CH_GT) begin
              tok_len = 16'd2;
              emit_open(KIND_SHR, 8'd0);
              state = ST_IDLE;
            end else begin
              emit_open(KIND_BAD, CH_GT);
              state = ST_DRAIN;
            end
          end
          ST_QUOTE: begin
            tok_len = bump16(tok_len);
            if (c == CH_QUOTE) begin
              emit_open(KIND_STRING, 8'd0);
              state = ST_IDLE;
            end
          end
          ST_WORD: begin
            if (word_byte(c)) begin
              tok_len = bump16(tok_len);
            end else begin
              emit_open(KIND_IDENT, 8'd0);
              begin_token(c);
            end
          end
          default: begin_token(c);
        endcase
        if (c == CH_LF) begin
          line_now = bump16(line_now);
          col_now = 16'd1;
        end else begin
          col_now = bump16(col_now);
        end
        if (offset_now != 32'hFFFF_FFFF) offset_now = offset_now + 32'd1;
      end
      foreach (step_out[i]) begin
        if (i == step_out.size() - 1) step_out[i].last = 1'b1;
        awaited.insert(awaited.size(), step_out[i]);
      end
    endfunction

    function void check_token(logic [TDATA_W-1:0] d, logic lst);
      token_t got;
      token_t want;
      got.kind = kind_t'(d[3:0]);
      got.line = d[19:4];
      got.col = d[35:20];
      got.offset = d[67:36];
      got.len = d[83:68];
      got.bad = d[91:84];
      got.last = lst;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected: kind %0d line %0d col %0d off %0d len %0d bad %0h last %0b",
                   got.kind, got.line, got.col, got.offset, got.len, got.bad, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Expected: kind %0d line %0d col %0d off %0d len %0d bad %0h last %0b",
                   want.kind, want.line, want.col, want.offset, want.len, want.bad, want.last);
          $display("Actual:   kind %0d line %0d col %0d off %0d len %0d bad %0h last %0b",
                   got.kind, got.line, got.col, got.offset, got.len, got.bad, got.last);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = 8'd0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  token_scoreboard sb = new();
  bit quiet = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;

  source_char_lexer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
  end

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int hold;
    forever begin
      hold = idle_len();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_item(input logic [7:0] c, input logic e);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= e;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_char(c, e);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_random_token();
    string puncts;
    string word_set;
    int pick;
    int n;
    logic [7:0] b;
    puncts = ";(){}[]";
    word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.#%";
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_item(puncts[$urandom_range(0, 6)], 1'b0);
    end else if (pick < 32) begin
      send_text("++");
    end else if (pick < 37) begin
      send_text("+++");
    end else if (pick < 43) begin
      send_text(">>");
    end else if (pick < 60) begin
      send_item(CH_QUOTE, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE) b = CH_LF;
        send_item(b, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) send_item(CH_QUOTE, 1'b0);
    end else if (pick < 85) begin
      n = $urandom_range(1, 8);
      repeat (n) send_item(word_set[$urandom_range(0, word_set.len() - 1)], 1'b0);
    end else if (pick < 88) begin
      send_item($urandom_range(0, 1) ? CH_PLUS : CH_GT, 1'b0);
    end else if (pick < 90) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      n = $urandom_range(0, 5);
      send_item((n == 5) ? CH_SPACE : CH_TAB + 8'(n), 1'b0);
    end
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(0, 5);
      send_item((n == 5) ? CH_SPACE : CH_TAB + 8'(n), 1'b0);
    end
    if ($urandom_range(0, 11) == 0) send_end();
  endtask

  initial begin
    int start_count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_end();
    send_text(";(){}[] ++ +++>>'a");
    send_item(8'h00, 1'b0);
    send_text("\nb' ab_.#%Z9;++;");
    send_end();
    send_text("+axyz");
    send_end();
    send_text(">;");
    send_end();
    send_item(8'hFF, 1'b0);
    send_end();
    send_item(8'h00, 1'b0);
    send_end();
    send_text("'open");
    send_end();
    send_text("+");
    send_end();
    send_text("++");
    send_end();
    send_text(">");
    send_end();
    send_text("id");
    send_end();

    start_count = items_sent;
    while (items_sent < start_count + 330) begin
      if ($urandom_range(0, 59) == 0) quiet = !quiet;
      send_random_token();
    end
    quiet = 1'b0;
    send_end();
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
